/* hdl/btcd_pkg.sv */
package btcd_pkg;

    localparam logic [1:0] KIND_BUS_WORD   = 2'd0;
    localparam logic [1:0] KIND_READ_REPLY = 2'd1;
    localparam logic [1:0] KIND_POWER      = 2'd2;

    localparam logic [3:0] MODE_DIRECT_OUT   = 4'd8;
    localparam logic [3:0] MODE_DIRECT_IN    = 4'd9;
    localparam logic [3:0] MODE_MASTER_RESET = 4'd11;
    localparam logic [3:0] MODE_WRAP         = 4'd12;

    localparam logic [1:0] FN_READ         = 2'd0;
    localparam logic [1:0] FN_WRITE        = 2'd1;
    localparam logic [1:0] FN_MASTER_RESET = 2'd2;
    localparam logic [1:0] FN_POWER_LOSS   = 2'd3;

    localparam logic       OUT_MODULE_CMD = 1'b0;
    localparam logic       OUT_RESPONSE   = 1'b1;

    localparam logic [2:0] SYNC_CODE = 3'b101;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] bus_word;
        logic        bus_select;
        logic        last_word;
        logic [15:0] module_read_data;
        logic        power_on;
    } t_in_item;

    typedef struct packed {
        logic        out_kind;
        logic [3:0]  module_index;
        logic [4:0]  module_channel;
        logic [1:0]  module_function;
        logic [15:0] module_write_data;
        logic [24:0] response_word;
        logic        response_bus;
        logic        last_result;
    } t_out_item;

    // A job is one result, or a broadcast that the back end repeats for every module.
    typedef struct packed {
        logic      broadcast;
        t_out_item result;
    } t_job;

endpackage

/* hdl/btcd_queue.sv */
module btcd_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  btcd_pkg::t_job  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output btcd_pkg::t_job  o_data
);
    import btcd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_slots [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slots[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + CW'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slots[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("Job queue holds more entries than its depth.");

endmodule

/* hdl/btcd_front.sv */
module btcd_front #(
    parameter int NUM_MODULES       = 16,
    parameter int MAX_MESSAGE_WORDS = 33
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic                i_full,
    input  btcd_pkg::t_in_item  i_item,
    input  logic                i_cfg_wr_en,
    input  logic [4:0]          i_cfg_wr_data,
    output logic                o_job_push,
    output btcd_pkg::t_job      o_job
);
    import btcd_pkg::*;

    localparam int WCW = $clog2(MAX_MESSAGE_WORDS + 2);

    logic [4:0]     r_terminal_address;
    logic           r_power, n_power;
    logic [WCW-1:0] r_word_count, n_word_count;
    logic [31:0]    r_command_word, n_command_word;
    logic [31:0]    r_first_data_word, n_first_data_word;
    logic           r_awaiting_reply, n_awaiting_reply;
    logic           r_reply_bus, n_reply_bus;

    logic           accept;
    logic [31:0]    cmd;
    logic [31:0]    dw;
    logic [WCW-1:0] len;
    logic           cmd_ok;
    logic           data_ok;
    logic           idx_ok;
    logic [3:0]     mode;
    t_job           job;
    logic           job_valid;

    function automatic logic [24:0] f_seal(input logic [24:0] w);
        return {w[24:1], ~^w[24:1]};
    endfunction

    assign accept = i_push && !i_full;
    assign cmd    = (r_word_count == '0) ? i_item.bus_word : r_command_word;
    assign dw     = (r_word_count == WCW'(1)) ? i_item.bus_word : r_first_data_word;
    assign len    = (r_word_count <= WCW'(MAX_MESSAGE_WORDS)) ? r_word_count + WCW'(1)
                                                             : r_word_count;
    assign mode   = cmd[18:15];
    assign cmd_ok = (cmd[24:20] == r_terminal_address) && (^cmd);
    assign idx_ok = ({1'b0, cmd[14:11]} < 5'(NUM_MODULES));
    assign data_ok = (7'(len) == 7'(cmd[5:1]) + 7'd2) && (^dw)
                     && (dw[24:20] == r_terminal_address) && (dw[3:1] == SYNC_CODE);

    always_comb begin
        n_power           = r_power;
        n_word_count      = r_word_count;
        n_command_word    = r_command_word;
        n_first_data_word = r_first_data_word;
        n_awaiting_reply  = r_awaiting_reply;
        n_reply_bus       = r_reply_bus;
        job               = '0;
        job_valid         = 1'b0;
        if (accept) begin
            case (i_item.kind)
                KIND_BUS_WORD: begin
                    if (r_power) begin
                        if (r_word_count == '0) begin
                            n_command_word = i_item.bus_word;
                        end else if (r_word_count == WCW'(1)) begin
                            n_first_data_word = i_item.bus_word;
                        end
                        n_word_count = len;
                        if (i_item.last_word) begin
                            n_word_count = '0;
                            if (len <= WCW'(MAX_MESSAGE_WORDS) && cmd_ok) begin
                                case (mode)
                                    MODE_DIRECT_OUT: begin
                                        if (data_ok && idx_ok) begin
                                            job_valid = 1'b1;
                                            job.result.module_index      = cmd[14:11];
                                            job.result.module_channel    = cmd[10:6];
                                            job.result.module_function   = FN_WRITE;
                                            job.result.module_write_data = dw[19:4];
                                        end
                                    end
                                    MODE_DIRECT_IN: begin
                                        if (idx_ok) begin
                                            job_valid = 1'b1;
                                            job.result.module_index    = cmd[14:11];
                                            job.result.module_channel  = cmd[10:6];
                                            job.result.module_function = FN_READ;
                                            n_awaiting_reply = 1'b1;
                                            n_reply_bus      = i_item.bus_select;
                                        end
                                    end
                                    MODE_MASTER_RESET: begin
                                        job_valid = 1'b1;
                                        job.broadcast = 1'b1;
                                        job.result.module_function = FN_MASTER_RESET;
                                    end
                                    MODE_WRAP: begin
                                        job_valid = 1'b1;
                                        job.result.out_kind      = OUT_RESPONSE;
                                        job.result.response_word = f_seal({r_terminal_address,
                                            1'b0, MODE_WRAP, cmd[12:1], 3'b000});
                                        job.result.response_bus  = i_item.bus_select;
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                        end
                    end
                end
                KIND_READ_REPLY: begin
                    if (r_power && r_awaiting_reply) begin
                        n_awaiting_reply = 1'b0;
                        job_valid = 1'b1;
                        job.result.out_kind      = OUT_RESPONSE;
                        job.result.response_word = f_seal({r_terminal_address,
                            i_item.module_read_data, SYNC_CODE, 1'b0});
                        job.result.response_bus  = r_reply_bus;
                    end
                end
                KIND_POWER: begin
                    if (i_item.power_on) begin
                        n_power = 1'b1;
                    end else if (r_power) begin
                        n_power          = 1'b0;
                        n_word_count     = '0;
                        n_awaiting_reply = 1'b0;
                        job_valid = 1'b1;
                        job.broadcast = 1'b1;
                        job.result.module_function = FN_POWER_LOSS;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_job_push = job_valid;
    assign o_job      = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_terminal_address <= '0;
            r_power            <= 1'b1;
            r_word_count       <= '0;
            r_command_word     <= '0;
            r_first_data_word  <= '0;
            r_awaiting_reply   <= 1'b0;
            r_reply_bus        <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_terminal_address <= i_cfg_wr_data;
            end
            r_power           <= n_power;
            r_word_count      <= n_word_count;
            r_command_word    <= n_command_word;
            r_first_data_word <= n_first_data_word;
            r_awaiting_reply  <= n_awaiting_reply;
            r_reply_bus       <= n_reply_bus;
        end
    end

    a_await_powered : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_awaiting_reply |-> r_power)
        else $error("A reply is awaited while power is off.");

    a_off_no_message : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_power |-> (r_word_count == '0))
        else $error("Message words are held while power is off.");

endmodule

/* hdl/btcd_back.sv */
module btcd_back #(
    parameter int NUM_MODULES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_empty,
    input  btcd_pkg::t_job      i_job,
    output logic                o_job_pop,
    output logic                o_empty,
    input  logic                i_pop,
    output btcd_pkg::t_out_item o_item
);
    import btcd_pkg::*;

    logic      r_valid;
    t_out_item r_item;
    logic [3:0] r_index, n_index;
    logic      load;
    logic      emit;
    logic      job_last;
    t_out_item result;

    assign load     = !r_valid || i_pop;
    assign emit     = load && !i_job_empty;
    assign job_last = !i_job.broadcast || (r_index == 4'(NUM_MODULES - 1));

    always_comb begin
        result             = i_job.result;
        result.last_result = job_last;
        if (i_job.broadcast) begin
            result.module_index = r_index;
        end
        n_index = r_index;
        if (emit) begin
            n_index = job_last ? '0 : r_index + 4'd1;
        end
    end

    assign o_job_pop = emit && job_last;
    assign o_empty   = !r_valid;
    assign o_item    = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_index <= '0;
        end else begin
            if (load) begin
                r_valid <= !i_job_empty;
            end
            r_index <= n_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_item <= result;
        end
    end

    a_index_in_broadcast : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_index != '0) |-> (!i_job_empty && i_job.broadcast))
        else $error("Broadcast counter runs without a broadcast job at the queue head.");

endmodule

/* hdl/bus_terminal_command_decoder_top.sv */
// Remote terminal command decoder for a command/data word bus.
// Input channel: drive i_in_item and raise push; the transaction completes at a
// clock edge where push is high and full is low. Bus words, module read replies
// and power status updates share this channel.
// Result channel: while empty is low, o_out_item holds the oldest result; it is
// taken at a clock edge where pop is high. last_result marks the final result
// caused by one input transaction.
// The terminal address is written through i_cfg_wr_en and i_cfg_wr_data; the user
// must write it only while the block is idle, which the block itself does not enforce.
// One input transaction is accepted every cycle while full is low. Its first
// result is written into the job queue at the accepting edge and moves on into
// the result register when that register is free. A master reset or a power drop
// yields one result per module; every other transaction yields at most one, so
// the result register sets the rate at one result per cycle while pop stays high.
// A queue of decoded jobs sits between the decoder and the result register;
// when the receiver stalls it fills and full rises, and no result is lost.
// Reset clears the queue and the message state, marks power present and sets
// the terminal address to zero.
module bus_terminal_command_decoder_top #(
    parameter int NUM_MODULES       = 16,
    parameter int MAX_MESSAGE_WORDS = 33,
    parameter int QUEUE_DEPTH       = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  btcd_pkg::t_in_item  i_in_item,
    output logic                empty,
    input  logic                pop,
    output btcd_pkg::t_out_item o_out_item,
    input  logic                i_cfg_wr_en,
    input  logic [4:0]          i_cfg_wr_data
);
    import btcd_pkg::*;

    logic job_push;
    t_job job_in;
    logic job_pop;
    logic job_empty;
    t_job job_head;

    btcd_front #(
        .NUM_MODULES       (NUM_MODULES),
        .MAX_MESSAGE_WORDS (MAX_MESSAGE_WORDS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_item        (i_in_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_job_push    (job_push),
        .o_job         (job_in)
    );

    btcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_data  (job_head)
    );

    btcd_back #(
        .NUM_MODULES (NUM_MODULES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_head),
        .o_job_pop   (job_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_item      (o_out_item)
    );

endmodule

/* verif/bus_terminal_command_decoder_top_tb.sv */
`timescale 1ns / 1ps

module bus_terminal_command_decoder_top_tb;
    import btcd_pkg::*;

    localparam int N_MODULES    = 16;
    localparam int MAX_WORDS    = 33;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef enum {
        DEF_NONE,
        DEF_CMD_PARITY,
        DEF_CMD_ADDR,
        DEF_DATA_PARITY,
        DEF_DATA_ADDR,
        DEF_SYNC,
        DEF_SHORT,
        DEF_LONG
    } t_write_defect;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    t_in_item   i_in_item = '0;
    logic       empty;
    logic       pop = 1'b0;
    t_out_item  o_out_item;
    logic       i_cfg_wr_en = 1'b0;
    logic [4:0] i_cfg_wr_data = '0;

    // Terminal state as the decoder should hold it.
    logic [4:0]  term_addr    = '0;
    logic        powered      = 1'b1;
    int          words_seen   = 0;
    logic [31:0] held_command = '0;
    logic [31:0] held_data    = '0;
    logic        read_pending = 1'b0;
    logic        read_bus     = 1'b0;

    t_out_item   expected_outputs[$];
    logic [31:0] message_words[$];
    int          mismatch_count = 0;
    int          items_sent     = 0;
    int          cycle_count    = 0;
    int          stall_request  = 0;
    logic        quiet_mode     = 1'b0;

    bus_terminal_command_decoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_in_item     (i_in_item),
        .empty         (empty),
        .pop           (pop),
        .o_out_item    (o_out_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic t_out_item module_command(input logic [3:0] idx, input logic [4:0] ch,
                                                 input logic [1:0] fn, input logic [15:0] data);
        t_out_item r;
        r                   = '0;
        r.out_kind          = OUT_MODULE_CMD;
        r.module_index      = idx;
        r.module_channel    = ch;
        r.module_function   = fn;
        r.module_write_data = data;
        return r;
    endfunction

    function automatic t_out_item bus_response(input logic [24:0] body, input logic bus);
        t_out_item r;
        r               = '0;
        r.out_kind      = OUT_RESPONSE;
        r.response_word = body | 25'(~^body);
        r.response_bus  = bus;
        return r;
    endfunction

    function automatic void compute_terminal_outputs(input t_in_item it);
        t_out_item res[$];
        t_out_item r;
        int        len;
        case (it.kind)
            KIND_BUS_WORD: begin
                if (powered) begin
                    if (words_seen == 0) held_command = it.bus_word;
                    else if (words_seen == 1) held_data = it.bus_word;
                    if (words_seen <= MAX_WORDS) words_seen++;
                    if (it.last_word) begin
                        len        = words_seen;
                        words_seen = 0;
                        if (len <= MAX_WORDS && held_command[24:20] == term_addr
                            && ^held_command) begin
                            case (held_command[18:15])
                                MODE_DIRECT_OUT: begin
                                    if (len == int'(held_command[5:1]) + 2 && ^held_data
                                        && held_data[24:20] == term_addr
                                        && held_data[3:1] == SYNC_CODE
                                        && int'(held_command[14:11]) < N_MODULES)
                                        res.push_back(module_command(held_command[14:11],
                                            held_command[10:6], FN_WRITE, held_data[19:4]));
                                end
                                MODE_DIRECT_IN: begin
                                    if (int'(held_command[14:11]) < N_MODULES) begin
                                        res.push_back(module_command(held_command[14:11],
                                            held_command[10:6], FN_READ, 16'h0));
                                        read_pending = 1'b1;
                                        read_bus     = it.bus_select;
                                    end
                                end
                                MODE_MASTER_RESET: begin
                                    for (int m = 0; m < N_MODULES; m++)
                                        res.push_back(module_command(4'(m), 5'd0,
                                            FN_MASTER_RESET, 16'h0));
                                end
                                MODE_WRAP: begin
                                    res.push_back(bus_response({term_addr, 1'b0, MODE_WRAP,
                                        held_command[12:1], 3'b000}, it.bus_select));
                                end
                                default: ;
                            endcase
                        end
                    end
                end
            end
            KIND_READ_REPLY: begin
                if (powered && read_pending) begin
                    read_pending = 1'b0;
                    res.push_back(bus_response({term_addr, it.module_read_data, SYNC_CODE,
                        1'b0}, read_bus));
                end
            end
            KIND_POWER: begin
                if (it.power_on) begin
                    powered = 1'b1;
                end else if (powered) begin
                    powered      = 1'b0;
                    words_seen   = 0;
                    read_pending = 1'b0;
                    for (int m = 0; m < N_MODULES; m++)
                        res.push_back(module_command(4'(m), 5'd0, FN_POWER_LOSS, 16'h0));
                end
            end
            default: ;
        endcase
        foreach (res[i]) begin
            r             = res[i];
            r.last_result = (i == res.size() - 1);
            expected_outputs.push_back(r);
        end
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void check_result(input t_out_item got);
        t_out_item want;
        if (expected_outputs.size() == 0) begin
            $error("result with no transaction waiting for it: %h", got);
            mismatch_count++;
        end else begin
            want = expected_outputs.pop_front();
            compare_field("out_kind", 32'(want.out_kind), 32'(got.out_kind));
            compare_field("module_index", 32'(want.module_index), 32'(got.module_index));
            compare_field("module_channel", 32'(want.module_channel), 32'(got.module_channel));
            compare_field("module_function", 32'(want.module_function),
                          32'(got.module_function));
            compare_field("module_write_data", 32'(want.module_write_data),
                          32'(got.module_write_data));
            compare_field("response_word", 32'(want.response_word), 32'(got.response_word));
            compare_field("response_bus", 32'(want.response_bus), 32'(got.response_bus));
            compare_field("last_result", 32'(want.last_result), 32'(got.last_result));
        end
    endfunction

    // The receiver checks every transaction it takes; a requested hold-off is counted here.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) check_result(o_out_item);
            if (stall_request > 0) begin
                hold_left     = stall_request;
                stall_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (quiet_mode) begin
                pop <= 1'b1;
            end else begin
                pop <= ($urandom_range(99) >= 26);
            end
        end
    end

    function automatic t_in_item make_item(input logic [1:0] kind, input logic [31:0] word,
                                           input logic bus, input logic last,
                                           input logic [15:0] rdata, input logic pwr);
        t_in_item it;
        it.kind             = kind;
        it.bus_word         = word;
        it.bus_select       = bus;
        it.last_word        = last;
        it.module_read_data = rdata;
        it.power_on         = pwr;
        return it;
    endfunction

    function automatic t_in_item reply_item(input logic [15:0] rdata);
        return make_item(KIND_READ_REPLY, $urandom, 1'($urandom), 1'($urandom), rdata,
                         1'($urandom));
    endfunction

    function automatic t_in_item power_item(input logic pwr);
        return make_item(KIND_POWER, $urandom, 1'($urandom), 1'($urandom), 16'($urandom), pwr);
    endfunction

    function automatic logic [31:0] make_command(input logic [4:0] addr, input logic [3:0] mode,
                                                 input logic [3:0] idx, input logic [4:0] ch,
                                                 input logic [4:0] cnt_m1, input logic good);
        logic [31:0] w;
        w        = $urandom;
        w[24:20] = addr;
        w[18:15] = mode;
        w[14:11] = idx;
        w[10:6]  = ch;
        w[5:1]   = cnt_m1;
        w[0]     = 1'b0;
        w[0]     = good ? ~^w : ^w;
        return w;
    endfunction

    function automatic logic [31:0] make_data_word(input logic [4:0] addr,
                                                   input logic [15:0] data,
                                                   input logic [2:0] sync, input logic good);
        logic [31:0] w;
        w        = $urandom;
        w[24:20] = addr;
        w[19:4]  = data;
        w[3:1]   = sync;
        w[0]     = 1'b0;
        w[0]     = good ? ~^w : ^w;
        return w;
    endfunction

    task automatic send_item(input t_in_item it);
        while (!quiet_mode && $urandom_range(99) < 26) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        compute_terminal_outputs(it);
        if (it.kind != KIND_UNUSED) items_sent++;
    endtask

    task automatic send_message(input logic bus);
        int last_idx;
        last_idx = message_words.size() - 1;
        for (int i = 0; i <= last_idx; i++)
            send_item(make_item(KIND_BUS_WORD, message_words[i], bus, i == last_idx,
                                16'($urandom), 1'($urandom)));
        message_words.delete();
    endtask

    task automatic send_single(input logic [31:0] word, input logic bus);
        message_words.push_back(word);
        send_message(bus);
    endtask

    task automatic send_write_message(input logic [4:0] cnt_m1, input t_write_defect defect,
                                      input logic [15:0] data, input logic bus);
        logic [4:0] cmd_addr;
        logic [4:0] data_addr;
        logic [2:0] sync;
        int         n_words;
        cmd_addr  = (defect == DEF_CMD_ADDR) ? term_addr + 5'd1 + 5'($urandom_range(30))
                                             : term_addr;
        data_addr = (defect == DEF_DATA_ADDR) ? term_addr + 5'd1 + 5'($urandom_range(30))
                                              : term_addr;
        sync      = (defect == DEF_SYNC) ? SYNC_CODE + 3'd1 + 3'($urandom_range(6))
                                         : SYNC_CODE;
        n_words   = int'(cnt_m1) + 2;
        if (defect == DEF_SHORT) n_words--;
        if (defect == DEF_LONG) n_words++;
        message_words.push_back(make_command(cmd_addr, MODE_DIRECT_OUT, 4'($urandom),
                                             5'($urandom), cnt_m1, defect != DEF_CMD_PARITY));
        if (n_words > 1)
            message_words.push_back(make_data_word(data_addr, data, sync,
                                                   defect != DEF_DATA_PARITY));
        while (message_words.size() < n_words) message_words.push_back($urandom);
        send_message(bus);
    endtask

    task automatic send_long_message(input logic bus);
        int n_words;
        n_words = MAX_WORDS + 1 + $urandom_range(2);
        message_words.push_back(make_command(term_addr, MODE_WRAP, 4'($urandom), 5'($urandom),
                                             5'($urandom), 1'b1));
        while (message_words.size() < n_words) message_words.push_back($urandom);
        send_message(bus);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (expected_outputs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_terminal_address(input logic [4:0] addr);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= addr;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        term_addr = addr;
    endtask

    task automatic test_wrap_echo();
        send_single(make_command(term_addr, MODE_WRAP, 4'hF, 5'h1F, 5'h1F, 1'b1), 1'b1);
        send_single(make_command(term_addr, MODE_WRAP, 4'h0, 5'h00, 5'h00, 1'b1), 1'b0);
        send_item(make_item(KIND_UNUSED, $urandom, 1'b1, 1'b1, 16'hFFFF, 1'b0));
        set_terminal_address(5'd31);
        message_words.push_back(make_command(term_addr, MODE_WRAP, 4'hA, 5'h15, 5'h0A, 1'b1));
        message_words.push_back($urandom);
        send_message(1'b1);
        wait_idle();
    endtask

    task automatic test_direct_output();
        send_write_message(5'd0, DEF_NONE, 16'hFFFF, 1'b1);
        send_write_message(5'd1, DEF_NONE, 16'h0000, 1'b0);
        send_write_message(5'd1, DEF_SHORT, 16'h1234, 1'b0);
        send_write_message(5'd0, DEF_DATA_PARITY, 16'hA5A5, 1'b1);
        send_write_message(5'd0, DEF_SYNC, 16'h5A5A, 1'b0);
        send_write_message(5'd0, DEF_CMD_ADDR, 16'h0F0F, 1'b1);
        send_write_message(5'd0, DEF_SHORT, 16'hFFFF, 1'b0);
        wait_idle();
    endtask

    task automatic test_direct_input();
        send_single(make_command(term_addr, MODE_DIRECT_IN, 4'hF, 5'h1F, 5'h00, 1'b1), 1'b1);
        send_item(reply_item(16'hFFFF));
        send_item(reply_item(16'h0000));
        send_single(make_command(term_addr, MODE_DIRECT_IN, 4'h0, 5'h00, 5'h00, 1'b1), 1'b0);
        send_single(make_command(term_addr, MODE_DIRECT_IN, 4'h7, 5'h0C, 5'h03, 1'b1), 1'b1);
        send_item(reply_item(16'h0000));
        wait_idle();
    endtask

    task automatic test_master_reset();
        send_single(make_command(term_addr, MODE_MASTER_RESET, 4'h3, 5'h09, 5'h00, 1'b1), 1'b0);
        wait_idle();
    endtask

    task automatic test_power_loss();
        send_single(make_command(term_addr, MODE_DIRECT_IN, 4'h2, 5'h04, 5'h00, 1'b1), 1'b0);
        send_item(power_item(1'b0));
        send_single(make_command(term_addr, MODE_WRAP, 4'h1, 5'h01, 5'h00, 1'b1), 1'b1);
        send_item(reply_item(16'hBEEF));
        send_item(power_item(1'b0));
        send_item(power_item(1'b1));
        send_item(power_item(1'b1));
        send_item(reply_item(16'hCAFE));
        send_single(make_command(term_addr, MODE_WRAP, 4'h6, 5'h11, 5'h02, 1'b1), 1'b1);
        wait_idle();
    endtask

    // The receiver holds off while the sender keeps offering, so the block fills and stalls.
    task automatic test_backpressure();
        quiet_mode    = 1'b1;
        stall_request = 300;
        repeat (6) begin
            send_single(make_command(term_addr, MODE_MASTER_RESET, 4'($urandom), 5'($urandom),
                                     5'($urandom), 1'b1), 1'($urandom));
            send_single(make_command(term_addr, MODE_WRAP, 4'($urandom), 5'($urandom),
                                     5'($urandom), 1'b1), 1'($urandom));
        end
        wait_idle();
        quiet_mode = 1'b0;
    endtask

    task automatic test_random_traffic(input int n_items, input logic [4:0] addr,
                                       input logic no_idle);
        int         target;
        int         sel;
        int         k;
        logic       bus;
        logic [31:0] w;
        set_terminal_address(addr);
        quiet_mode = no_idle;
        target     = items_sent + n_items;
        send_long_message(1'($urandom));
        while (items_sent < target) begin
            sel = $urandom_range(99);
            bus = 1'($urandom);
            if (sel < 24) begin
                send_write_message(5'(($urandom_range(7) == 0) ? $urandom_range(31)
                                                                : $urandom_range(2)),
                                   DEF_NONE, 16'($urandom), bus);
            end else if (sel < 38) begin
                send_single(make_command(term_addr, MODE_DIRECT_IN, 4'($urandom), 5'($urandom),
                                         5'($urandom), 1'b1), bus);
                if ($urandom_range(4) != 0) send_item(reply_item(16'($urandom)));
            end else if (sel < 50) begin
                message_words.push_back(make_command(term_addr, MODE_WRAP, 4'($urandom),
                                                     5'($urandom), 5'($urandom), 1'b1));
                k = $urandom_range(2);
                repeat (k) message_words.push_back($urandom);
                send_message(bus);
            end else if (sel < 54) begin
                send_single(make_command(term_addr, MODE_MASTER_RESET, 4'($urandom),
                                         5'($urandom), 5'($urandom), 1'b1), bus);
            end else if (sel < 68) begin
                send_write_message(5'($urandom_range(3)), t_write_defect'($urandom_range(1, 7)),
                                   16'($urandom), bus);
            end else if (sel < 78) begin
                k = $urandom_range(1, 4);
                repeat (k) begin
                    w = $urandom;
                    if ($urandom_range(1) == 1) w[24:20] = term_addr;
                    message_words.push_back(w);
                end
                send_message(bus);
            end else if (sel < 86) begin
                send_item(reply_item(16'($urandom)));
            end else if (sel < 90) begin
                send_item(power_item(1'b0));
                k = $urandom_range(3);
                repeat (k)
                    send_item(make_item(2'($urandom_range(1)), $urandom, 1'($urandom),
                                        1'($urandom), 16'($urandom), 1'($urandom)));
                if ($urandom_range(1) == 1) send_item(power_item(1'b0));
                send_item(power_item(1'b1));
            end else if (sel < 93) begin
                if ($urandom_range(1) == 1)
                    send_item(make_item(KIND_UNUSED, $urandom, 1'($urandom), 1'($urandom),
                                        16'($urandom), 1'($urandom)));
                else
                    send_item(power_item(1'b1));
            end else if (sel < 95) begin
                send_long_message(bus);
            end else begin
                message_words.push_back(make_command(term_addr, 4'($urandom), 4'($urandom),
                                                     5'($urandom), 5'($urandom), 1'b1));
                if ($urandom_range(1) == 1) message_words.push_back($urandom);
                send_message(bus);
            end
        end
        wait_idle();
        quiet_mode = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_wrap_echo();
        test_direct_output();
        test_direct_input();
        test_master_reset();
        test_power_loss();
        test_backpressure();
        test_random_traffic(80, 5'd31, 1'b0);
        test_random_traffic(80, 5'd0, 1'b1);
        test_random_traffic(80, 5'($urandom), 1'b0);
        test_random_traffic(80, 5'd21, 1'b0);
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
